// File: design/tcld_pkg.sv
// Package for the text command line decoder: shared types, event and LED codes.
// No dependencies; imported by tcld_match, text_command_line_decoder and tb_top.
`timescale 1ns / 1ps
`default_nettype none

package tcld_pkg;

	// Bytes of a line kept for command matching
	localparam int unsigned PREFIX_DEPTH = 16;

	// Event codes carried on the result tuser
	localparam logic [1:0] EV_LED     = 2'd0;
	localparam logic [1:0] EV_MOTOR   = 2'd1;
	localparam logic [1:0] EV_UNKNOWN = 2'd2;

	// LED state codes
	localparam logic [1:0] LED_OFF   = 2'd0;
	localparam logic [1:0] LED_WHITE = 2'd1;
	localparam logic [1:0] LED_RED   = 2'd2;
	localparam logic [1:0] LED_GREEN = 2'd3;

	// Line control characters
	localparam logic [7:0] BYTE_LF = 8'd10;
	localparam logic [7:0] BYTE_CR = 8'd13;

	// Line prefix, entry 0 is the first byte of the line
	typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

	// Classification of one finished line
	typedef struct packed {
		logic       ignore;     // empty line or heartbeat
		logic       led_set;
		logic [1:0] led_val;
		logic       motor_set;
		logic [1:0] motor_val;
	} match_t;

endpackage

`default_nettype wire

// File: design/text_command_line_decoder.sv
// Top level of the text command line decoder: byte stage, line state, result register.
// Depends on tcld_pkg and tcld_match.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  tdata                                          tuser
// s_axis    in         [7:0] rx_byte                                  -
// m_axis    out        [1:0] led_state, [3:2] motor_gear,             [1:0] event_res
//                      [9:4] unknown_length, [15:10] zero
//
// One byte per cycle while the result register can take a beat: a byte is registered,
// then the line state and, on a newline, the command match run combinationally into the result register.
// An accepted newline passes through the byte stage register and then the result register.
// arst_n clears the line length, overflow flag, CR mark, LED and motor state and valids.
// A held result stalls the byte stage only; with the result taken no stall occurs.
module text_command_line_decoder #(
	parameter int unsigned LINE_BYTES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // led_state, motor_gear, unknown_length, pad
	output logic [1:0]       m_axis_tuser    // [1:0] event_res
);
	import tcld_pkg::*;

	localparam int unsigned LEN_W = $clog2(LINE_BYTES);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic [LEN_W-1:0]  len_q;
	logic              ovf_q;
	logic              cr_q;
	prefix_t           prefix_q;
	logic [1:0]        led_q;
	logic [1:0]        motor_q;
	logic              out_valid_q;
	logic [1:0]        out_user_q;
	logic [15:0]       out_data_q;

	logic              out_free;
	logic              proc;
	logic              is_lf;
	logic [LEN_W-1:0]  len_eff;
	logic              len_short;
	match_t            match;
	logic              emit;
	logic [1:0]        led_next;
	logic [1:0]        motor_next;
	logic [1:0]        ev_code;
	logic [5:0]        unk_len;

	// Handshake: byte stage moves whenever the result register can take a beat
	assign out_free      = !out_valid_q || m_axis_tready;
	assign proc          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// Line length with a trailing CR stripped
	assign is_lf     = (byte_s1 == BYTE_LF);
	assign len_eff   = len_q - LEN_W'(cr_q && (len_q != '0));
	assign len_short = (32'(len_eff) <= 32'(PREFIX_DEPTH));

	tcld_match u_match (
		.prefix (prefix_q),
		.len    (len_eff[4:0]),
		.short  (len_short),
		.result (match)
	);

	// Classify the finished line
	always_comb begin
		emit       = is_lf && !ovf_q && !match.ignore;
		led_next   = match.led_set ? match.led_val : led_q;
		motor_next = match.motor_set ? match.motor_val : motor_q;
		if (match.led_set) begin
			ev_code = EV_LED;
		end else if (match.motor_set) begin
			ev_code = EV_MOTOR;
		end else begin
			ev_code = EV_UNKNOWN;
		end
		unk_len = '0;
		if (ev_code == EV_UNKNOWN) begin
			unk_len = (32'(len_eff) > 32'd63) ? 6'd63 : 6'(len_eff);
		end
	end

	// Byte stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Line state and kept LED and motor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ovf_q   <= 1'b0;
			cr_q    <= 1'b0;
			led_q   <= LED_OFF;
			motor_q <= '0;
		end else if (proc) begin
			if (is_lf) begin
				len_q <= '0;
				ovf_q <= 1'b0;
				cr_q  <= 1'b0;
				if (!ovf_q) begin
					led_q   <= led_next;
					motor_q <= motor_next;
				end
			end else if (!ovf_q) begin
				if (len_q == LEN_W'(LINE_BYTES - 1)) begin
					ovf_q <= 1'b1;
				end else begin
					len_q <= len_q + LEN_W'(1);
					cr_q  <= (byte_s1 == BYTE_CR);
				end
			end
		end
	end

	// Store the first bytes of the line
	always_ff @(posedge clk) begin
		if (proc && !is_lf && !ovf_q && len_q != LEN_W'(LINE_BYTES - 1)
			&& 32'(len_q) < 32'(PREFIX_DEPTH)) begin
			prefix_q[len_q[3:0]] <= byte_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= proc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			out_user_q <= ev_code;
			out_data_q <= {6'd0, unk_len, motor_next, led_next};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// File: design/tcld_match.sv
// Command matcher: compares the kept line prefix against the known commands.
// Depends on tcld_pkg for prefix_t, match_t and the LED codes.
`timescale 1ns / 1ps
`default_nettype none

module tcld_match (
	input  tcld_pkg::prefix_t prefix,
	input  logic [4:0]        len,      // line length after CR strip, valid when short
	input  logic              short,    // line fits in the prefix
	output tcld_pkg::match_t  result
);
	import tcld_pkg::*;

	localparam logic [31:0] STR_PING  = "ping";
	localparam logic [31:0] STR_PONG  = "pong";
	localparam logic [47:0] STR_ON    = "led_on";
	localparam logic [55:0] STR_OFF   = "led_off";
	localparam logic [79:0] STR_COLOR = {"led_", "color_"};
	localparam logic [39:0] STR_WHITE = "white";
	localparam logic [23:0] STR_RED   = "red";
	localparam logic [39:0] STR_GREEN = "green";
	localparam logic [95:0] STR_MOTOR = {"motor_", "speed_"};
	localparam logic [5:0]  DIGIT_HI  = 6'b001100;   // '0'..'3' share these upper bits

	logic [31:0] head4;
	logic [47:0] head6;
	logic [55:0] head7;
	logic [79:0] head10;
	logic [95:0] head12;
	logic [39:0] tail5;
	logic [23:0] tail3;
	logic        is_ping;
	logic        is_on;
	logic        is_off;
	logic        is_white;
	logic        is_red;
	logic        is_green;
	logic        is_motor;

	// Gather prefix slices in text order
	assign head4  = {prefix[0], prefix[1], prefix[2], prefix[3]};
	assign head6  = {head4, prefix[4], prefix[5]};
	assign head7  = {head6, prefix[6]};
	assign head10 = {head7, prefix[7], prefix[8], prefix[9]};
	assign head12 = {head10, prefix[10], prefix[11]};
	assign tail3  = {prefix[10], prefix[11], prefix[12]};
	assign tail5  = {tail3, prefix[13], prefix[14]};

	// Compare against each command, length first
	assign is_ping  = short && (len == 5'd4) && (head4 == STR_PING || head4 == STR_PONG);
	assign is_on    = short && (len == 5'd6) && (head6 == STR_ON);
	assign is_off   = short && (len == 5'd7) && (head7 == STR_OFF);
	assign is_white = short && (len == 5'd15) && (head10 == STR_COLOR) && (tail5 == STR_WHITE);
	assign is_green = short && (len == 5'd15) && (head10 == STR_COLOR) && (tail5 == STR_GREEN);
	assign is_red   = short && (len == 5'd13) && (head10 == STR_COLOR) && (tail3 == STR_RED);
	assign is_motor = short && (len == 5'd13) && (head12 == STR_MOTOR)
		&& (prefix[12][7:2] == DIGIT_HI);

	// Build the classification
	always_comb begin
		result.ignore    = (short && len == 5'd0) || is_ping;
		result.led_set   = is_on || is_off || is_white || is_red || is_green;
		result.led_val   = LED_OFF;
		if (is_on || is_white) begin
			result.led_val = LED_WHITE;
		end else if (is_red) begin
			result.led_val = LED_RED;
		end else if (is_green) begin
			result.led_val = LED_GREEN;
		end
		result.motor_set = is_motor;
		result.motor_val = prefix[12][1:0];
	end

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Testbench for text_command_line_decoder: byte stream in, line events out.
// Depends on tcld_pkg and the decoder RTL; predicts or tabulates each event and compares field by field.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import tcld_pkg::*;

	localparam int unsigned LINE_BYTES   = 64;
	localparam int unsigned RANDOM_BYTES = 1450;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned DRAIN_CYCLES = 12;

	// Command heads shared by several words
	localparam string LED_HEAD   = "led_";
	localparam string MOTOR_HEAD = "motor_";

	typedef enum logic [1:0] {ROW_PREDICT, ROW_FIXED, ROW_SILENT} row_kind_t;

	typedef struct packed {
		logic [1:0] ev;
		logic [1:0] led;
		logic [1:0] gear;
		logic [5:0] ulen;
	} line_event_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [1:0] led_state, [3:2] motor_gear, [9:4] unknown_length
	logic [1:0]  m_axis_tuser;   // [1:0] event_res

	// Predicted line state
	logic [7:0]  line_head [PREFIX_DEPTH];
	int unsigned line_len;
	bit          line_ovf;
	bit          line_cr;
	logic [1:0]  led_kept;
	logic [1:0]  gear_kept;

	line_event_t pending_events [$];
	logic [7:0]  line_buf [$];
	int          fail_count;
	bit          gaps_on;
	bit          long_hold_req;

	// Directed table, one entry per line
	string       row_text [$];
	int          row_pad [$];
	logic [7:0]  row_pad_byte [$];
	row_kind_t   row_kind [$];
	line_event_t row_event [$];

	string command_words [11] = '{"ping", "pong", "led_on", "led_off",
		{LED_HEAD, "color_white"}, {LED_HEAD, "color_red"}, {LED_HEAD, "color_green"},
		{MOTOR_HEAD, "speed_0"}, {MOTOR_HEAD, "speed_1"},
		{MOTOR_HEAD, "speed_2"}, {MOTOR_HEAD, "speed_3"}};

	text_command_line_decoder #(
		.LINE_BYTES(LINE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hang guard
	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

	// True when n equals the length of s and the line starts with s
	function automatic bit line_reads(input int unsigned n, input string s);
		if (n != s.len())
			return 1'b0;
		for (int i = 0; i < s.len(); i++)
			if (line_head[i] != s[i])
				return 1'b0;
		return 1'b1;
	endfunction

	// Advance the predicted state by one byte; return 1 with the event when a line yields one
	function automatic bit decode_byte(input logic [7:0] b, output line_event_t r);
		int unsigned n;
		bit          dropped;
		r = '0;
		if (b != BYTE_LF) begin
			if (!line_ovf) begin
				if (line_len + 1 >= LINE_BYTES) begin
					line_ovf = 1'b1;
				end else begin
					if (line_len < PREFIX_DEPTH)
						line_head[line_len] = b;
					line_len++;
					line_cr = (b == BYTE_CR);
				end
			end
			return 1'b0;
		end
		n       = line_len;
		dropped = line_ovf;
		if (n > 0 && line_cr)
			n--;
		line_len = 0;
		line_ovf = 1'b0;
		line_cr  = 1'b0;
		if (dropped || n == 0 || line_reads(n, "ping") || line_reads(n, "pong"))
			return 1'b0;
		r.ev = EV_UNKNOWN;
		if (line_reads(n, "led_on")) begin
			led_kept = LED_WHITE;
			r.ev = EV_LED;
		end else if (line_reads(n, "led_off")) begin
			led_kept = LED_OFF;
			r.ev = EV_LED;
		end else if (line_reads(n, {LED_HEAD, "color_white"})) begin
			led_kept = LED_WHITE;
			r.ev = EV_LED;
		end else if (line_reads(n, {LED_HEAD, "color_red"})) begin
			led_kept = LED_RED;
			r.ev = EV_LED;
		end else if (line_reads(n, {LED_HEAD, "color_green"})) begin
			led_kept = LED_GREEN;
			r.ev = EV_LED;
		end else if (n == 13 && line_reads(12, {MOTOR_HEAD, "speed_"}) &&
				line_head[12] >= "0" && line_head[12] <= "3") begin
			gear_kept = 2'(line_head[12] - "0");
			r.ev = EV_MOTOR;
		end
		r.led  = led_kept;
		r.gear = gear_kept;
		if (r.ev == EV_UNKNOWN)
			r.ulen = (n > 63) ? 6'd63 : n[5:0];
		return 1'b1;
	endfunction

	task automatic add_row(input string text, input int pad, input logic [7:0] pad_byte,
			input row_kind_t kind, input logic [1:0] ev, input logic [1:0] led,
			input logic [1:0] gear, input logic [5:0] ulen);
		line_event_t e;
		e.ev   = ev;
		e.led  = led;
		e.gear = gear;
		e.ulen = ulen;
		row_text.push_back(text);
		row_pad.push_back(pad);
		row_pad_byte.push_back(pad_byte);
		row_kind.push_back(kind);
		row_event.push_back(e);
	endtask

	// Send line_buf plus a newline, one beat per byte, and queue what it should yield
	task automatic send_line(input row_kind_t kind, input line_event_t fixed);
		line_event_t r;
		bit          got;
		line_buf.push_back(BYTE_LF);
		foreach (line_buf[i]) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= line_buf[i];
			do @(posedge clk); while (!s_axis_tready);
			got = decode_byte(line_buf[i], r);
			if (kind == ROW_FIXED && line_buf[i] == BYTE_LF)
				pending_events.push_back(fixed);
			else if (kind == ROW_PREDICT && got)
				pending_events.push_back(r);
			if (gaps_on && $urandom_range(0, 5) == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	// Mostly well-formed commands, then near misses, short noise and long lines
	task automatic build_random_line(input bit commands_only);
		string       word;
		int unsigned pick;
		int unsigned n;
		line_buf.delete();
		pick = commands_only ? 0 : $urandom_range(0, 99);
		if (pick < 72) begin
			word = (pick < 55) ? command_words[$urandom_range(0, 10)]
				: command_words[$urandom_range(2, 10)];
			for (int j = 0; j < word.len(); j++)
				line_buf.push_back(word[j]);
			if (pick >= 55) begin
				case ($urandom_range(0, 3))
					0: line_buf[$urandom_range(0, line_buf.size() - 1)] =
						8'($urandom_range(0, 255));
					1: void'(line_buf.pop_back());
					2: line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
					default: line_buf[line_buf.size() - 1] =
						8'($urandom_range(8'h2E, 8'h3A));
				endcase
			end
		end else begin
			n = (pick < 92) ? $urandom_range(0, 20) : $urandom_range(17, 70);
			repeat (n)
				line_buf.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 3) == 0)
			line_buf.push_back(BYTE_CR);
		if ($urandom_range(0, 15) == 0)
			line_buf.push_back(BYTE_CR);
	endtask

	// Result side: random stalls, plus one long hold-off on request
	initial begin : result_ready
		int unsigned hold_left;
		hold_left     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 6) == 0) begin
				hold_left = $urandom_range(0, 7);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin : check_result
		line_event_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_events.size() == 0) begin
				$error("unexpected result: event_res %0d unknown_length %0d",
					m_axis_tuser, m_axis_tdata[9:4]);
				fail_count++;
			end else begin
				want = pending_events.pop_front();
				if (m_axis_tuser != want.ev) begin
					$error("event_res expected %0d got %0d", want.ev, m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata[1:0] != want.led) begin
					$error("led_state expected %0d got %0d", want.led, m_axis_tdata[1:0]);
					fail_count++;
				end
				if (m_axis_tdata[3:2] != want.gear) begin
					$error("motor_gear expected %0d got %0d", want.gear, m_axis_tdata[3:2]);
					fail_count++;
				end
				if (m_axis_tdata[9:4] != want.ulen) begin
					$error("unknown_length expected %0d got %0d", want.ulen, m_axis_tdata[9:4]);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		string       text;
		int unsigned rand_bytes;
		int unsigned line_no;
		bit          burst;
		fail_count    = 0;
		gaps_on       = 1'b0;
		long_hold_req = 1'b0;
		line_len      = 0;
		line_ovf      = 1'b0;
		line_cr       = 1'b0;
		led_kept      = LED_OFF;
		gear_kept     = 2'd0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines: silent lines, ping, pong, every LED command, motor speeds 0, 2 and 3,
		// bad suffixes, CR handling, zero byte, long line, longest kept line, overflow and recovery
		add_row("", 0, 8'h00, ROW_SILENT, EV_LED, LED_OFF, 2'd0, 6'd0);
		add_row("ping", 0, 8'h00, ROW_SILENT, EV_LED, LED_OFF, 2'd0, 6'd0);
		add_row("pong\015", 0, 8'h00, ROW_SILENT, EV_LED, LED_OFF, 2'd0, 6'd0);
		add_row("led_on", 0, 8'h00, ROW_FIXED, EV_LED, LED_WHITE, 2'd0, 6'd0);
		add_row({MOTOR_HEAD, "speed_3"}, 0, 8'h00, ROW_FIXED, EV_MOTOR, LED_WHITE, 2'd3, 6'd0);
		add_row("led_off", 0, 8'h00, ROW_FIXED, EV_LED, LED_OFF, 2'd3, 6'd0);
		add_row({LED_HEAD, "color_red"}, 0, 8'h00, ROW_FIXED, EV_LED, LED_RED, 2'd3, 6'd0);
		add_row({LED_HEAD, "color_green\015"}, 0, 8'h00, ROW_FIXED, EV_LED, LED_GREEN,
			2'd3, 6'd0);
		add_row({LED_HEAD, "color_white"}, 0, 8'h00, ROW_FIXED, EV_LED, LED_WHITE, 2'd3, 6'd0);
		add_row({MOTOR_HEAD, "speed_0\015"}, 0, 8'h00, ROW_FIXED, EV_MOTOR, LED_WHITE,
			2'd0, 6'd0);
		add_row({MOTOR_HEAD, "speed_4"}, 0, 8'h00, ROW_FIXED, EV_UNKNOWN, LED_WHITE,
			2'd0, 6'd13);
		add_row({LED_HEAD, "color_blue"}, 0, 8'h00, ROW_FIXED, EV_UNKNOWN, LED_WHITE,
			2'd0, 6'd14);
		add_row("ping\015\015", 0, 8'h00, ROW_FIXED, EV_UNKNOWN, LED_WHITE, 2'd0, 6'd5);
		add_row("\015", 0, 8'h00, ROW_SILENT, EV_LED, LED_OFF, 2'd0, 6'd0);
		add_row("\015ping", 0, 8'h00, ROW_FIXED, EV_UNKNOWN, LED_WHITE, 2'd0, 6'd5);
		add_row("led_on", 1, 8'h00, ROW_FIXED, EV_UNKNOWN, LED_WHITE, 2'd0, 6'd7);
		add_row({LED_HEAD, "color_green"}, 2, "x", ROW_FIXED, EV_UNKNOWN, LED_WHITE,
			2'd0, 6'd17);
		add_row("", 63, 8'hFF, ROW_FIXED, EV_UNKNOWN, LED_WHITE, 2'd0, 6'd63);
		add_row("", 64, 8'hFF, ROW_SILENT, EV_LED, LED_OFF, 2'd0, 6'd0);
		add_row({MOTOR_HEAD, "speed_2"}, 0, 8'h00, ROW_PREDICT, EV_LED, LED_OFF, 2'd0, 6'd0);
		add_row("", 62, BYTE_CR, ROW_PREDICT, EV_LED, LED_OFF, 2'd0, 6'd0);
		add_row({MOTOR_HEAD, "speed_"}, 1, "/", ROW_PREDICT, EV_LED, LED_OFF, 2'd0, 6'd0);
		add_row("LED_ON", 0, 8'h00, ROW_PREDICT, EV_LED, LED_OFF, 2'd0, 6'd0);

		gaps_on = 1'b1;
		foreach (row_text[k]) begin
			text = row_text[k];
			line_buf.delete();
			for (int j = 0; j < text.len(); j++)
				line_buf.push_back(text[j]);
			repeat (row_pad[k])
				line_buf.push_back(row_pad_byte[k]);
			send_line(row_kind[k], row_event[k]);
		end

		// Pause the sender until every pending event has come out
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_events.size() != 0);

		// Random lines; the first burst runs against a long result hold-off
		rand_bytes = 0;
		line_no    = 0;
		while (rand_bytes < RANDOM_BYTES) begin
			burst = (line_no < 40);
			if (line_no == 0)
				long_hold_req = 1'b1;
			if (burst || rand_bytes + 250 > RANDOM_BYTES)
				gaps_on = 1'b0;
			else if (line_no == 40 || $urandom_range(0, 15) == 0)
				gaps_on = !gaps_on;
			build_random_line(burst);
			rand_bytes += line_buf.size() + 1;
			line_no++;
			send_line(ROW_PREDICT, '0);
		end

		// Drain and report
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_events.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// File: text_command_line_decoder.f
design/tcld_pkg.sv
design/tcld_match.sv
design/text_command_line_decoder.sv
test/tb_top.sv
